>>> rtl/cmp_pkg.sv
// Shared types and constants for the complex magnitude and phase converter.
package cmp_pkg;

    localparam int GUARD_BITS = 16;
    localparam int ANGLE_W    = 32;
    localparam int MAG_W      = 16;
    localparam int PHASE_W    = 16;
    localparam int LO_W       = 24;
    localparam int LO_PROD_W  = 56;
    localparam int SUM_W      = 64;
    localparam int RES_W      = SUM_W - LO_W;
    localparam int GAIN_W     = 32;

    localparam logic [GAIN_W-1:0]  INV_GAIN      = 32'd2608131496;
    localparam logic [ANGLE_W-1:0] HALF_PI_ANGLE = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] PHASE_ROUND   = 32'h0000_8000;
    localparam logic [SUM_W-1:0]   MAG_ROUND     = 64'h0000_0000_0080_0000;
    localparam logic [MAG_W-1:0]   MAG_MAX       = 16'hFFFF;

    localparam logic [PHASE_W-1:0] PHASE_ZERO     = 16'h0000;
    localparam logic [PHASE_W-1:0] PHASE_PI       = 16'h8000;
    localparam logic [PHASE_W-1:0] PHASE_HALF_PI  = 16'h4000;
    localparam logic [PHASE_W-1:0] PHASE_NHALF_PI = 16'hC000;

    localparam logic [ANGLE_W-1:0] ATAN_TABLE [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic               spec;
        logic               zero;
        logic [MAG_W-1:0]   mag;
        logic [PHASE_W-1:0] phase;
    } t_bypass;

endpackage

>>> rtl/complex_magnitude_phase.sv
// Pipelined CORDIC rectangular-to-polar converter, top level.
// Each request carries one complex sample; the result is its gain-compensated
// magnitude and its phase in (-pi, pi] with 32768 standing for pi, plus a
// flag for an exactly zero sample. One CORDIC micro-rotation per register
// stage, so one sample enters every cycle while the output is not stalled; a
// sample passes the input stage, which loads when its request is accepted,
// then CORDIC_STEPS rotation stages, one multiply stage and one output
// register.
// Backpressure on the output stalls only the stages that hold data; empty
// stages keep filling.
module complex_magnitude_phase #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // re, im
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // magnitude, phase
    output logic [31:0]                            o_m_axis_tdata,
    // zero_input
    output logic                                   o_m_axis_tuser
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int GB   = cmp_pkg::GUARD_BITS;
    localparam int DW   = SW + GB + 3;
    localparam int XH_W = DW - cmp_pkg::LO_W;
    localparam int EXT  = 33;

    logic signed [SW-1:0] n_re;
    logic signed [SW-1:0] n_im;
    logic signed [DW-1:0] n_xin;
    logic signed [DW-1:0] n_yin;
    logic [SW-1:0]        n_abs_re;
    logic [SW-1:0]        n_abs_im;
    logic [SW-1:0]        n_abs_sel;
    logic [EXT-1:0]       n_abs_ext;
    cmp_pkg::t_bypass     n_bp_in;

    logic signed [DW-1:0]         n_x [0:CORDIC_STEPS];
    logic signed [DW-1:0]         n_y [0:CORDIC_STEPS];
    logic [cmp_pkg::ANGLE_W-1:0]  n_z [0:CORDIC_STEPS];

    logic signed [DW-1:0]         r_x  [0:CORDIC_STEPS];
    logic signed [DW-1:0]         r_y  [0:CORDIC_STEPS];
    logic [cmp_pkg::ANGLE_W-1:0]  r_z  [0:CORDIC_STEPS];
    cmp_pkg::t_bypass             r_bp [0:CORDIC_STEPS];
    logic                         r_v  [0:CORDIC_STEPS];
    logic                         en   [0:CORDIC_STEPS];

    logic [DW-1:0]                     n_ux;
    logic [XH_W+cmp_pkg::GAIN_W-1:0]   n_phi;
    logic [cmp_pkg::LO_PROD_W-1:0]     n_plo;
    logic [XH_W+cmp_pkg::GAIN_W-1:0]   r_phi;
    logic [cmp_pkg::LO_PROD_W-1:0]     r_plo;
    logic [cmp_pkg::ANGLE_W-1:0]       r_mz;
    cmp_pkg::t_bypass                  r_mbp;
    logic                              r_mv;
    logic                              en_m;

    logic [cmp_pkg::SUM_W-1:0]    n_sum;
    logic [cmp_pkg::RES_W-1:0]    n_res;
    logic [cmp_pkg::ANGLE_W-1:0]  n_pz;
    logic [cmp_pkg::MAG_W-1:0]    n_mag;
    logic [cmp_pkg::PHASE_W-1:0]  n_phase;
    logic                         r_ov;
    logic [31:0]                  r_odata;
    logic                         r_ouser;
    logic                         en_o;

    // input stage: pre-rotation into the right half plane and axis bypass
    assign n_re  = i_s_axis_tdata[SW-1:0];
    assign n_im  = i_s_axis_tdata[2*SW-1:SW];
    assign n_xin = {{(DW-SW-GB){n_re[SW-1]}}, n_re, {GB{1'b0}}};
    assign n_yin = {{(DW-SW-GB){n_im[SW-1]}}, n_im, {GB{1'b0}}};

    assign n_x[0] = !n_re[SW-1] ? n_xin : (n_im[SW-1] ? -n_yin : n_yin);
    assign n_y[0] = !n_re[SW-1] ? n_yin : (n_im[SW-1] ? n_xin : -n_xin);
    assign n_z[0] = !n_re[SW-1] ? '0
                  : (n_im[SW-1] ? -cmp_pkg::HALF_PI_ANGLE : cmp_pkg::HALF_PI_ANGLE);

    assign n_abs_re  = n_re[SW-1] ? SW'(-n_re) : SW'(n_re);
    assign n_abs_im  = n_im[SW-1] ? SW'(-n_im) : SW'(n_im);
    assign n_abs_sel = (n_im == '0) ? n_abs_re : n_abs_im;
    assign n_abs_ext = {{(EXT-SW){1'b0}}, n_abs_sel};

    always_comb begin
        n_bp_in.spec  = (n_re == '0) || (n_im == '0);
        n_bp_in.zero  = (n_re == '0) && (n_im == '0);
        n_bp_in.mag   = (n_abs_ext > EXT'(cmp_pkg::MAG_MAX)) ? cmp_pkg::MAG_MAX
                                                            : n_abs_ext[cmp_pkg::MAG_W-1:0];
        if (n_im == '0) begin
            n_bp_in.phase = n_re[SW-1] ? cmp_pkg::PHASE_PI : cmp_pkg::PHASE_ZERO;
        end else begin
            n_bp_in.phase = n_im[SW-1] ? cmp_pkg::PHASE_NHALF_PI : cmp_pkg::PHASE_HALF_PI;
        end
    end

    assign en_o            = !r_ov || i_m_axis_tready;
    assign en_m            = !r_mv || en_o;
    assign en[CORDIC_STEPS] = !r_v[CORDIC_STEPS] || en_m;
    assign o_s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en[0]) begin
            r_v[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x[0]  <= n_x[0];
            r_y[0]  <= n_y[0];
            r_z[0]  <= n_z[0];
            r_bp[0] <= n_bp_in;
        end
    end

    // rotation stages
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        assign en[k] = !r_v[k] || en[k+1];

        assign n_x[k+1] = r_y[k][DW-1] ? r_x[k] - (r_y[k] >>> k) : r_x[k] + (r_y[k] >>> k);
        assign n_y[k+1] = r_y[k][DW-1] ? r_y[k] + (r_x[k] >>> k) : r_y[k] - (r_x[k] >>> k);
        assign n_z[k+1] = r_y[k][DW-1] ? r_z[k] - cmp_pkg::ATAN_TABLE[k]
                                       : r_z[k] + cmp_pkg::ATAN_TABLE[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en[k+1]) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k+1]) begin
                r_x[k+1]  <= n_x[k+1];
                r_y[k+1]  <= n_y[k+1];
                r_z[k+1]  <= n_z[k+1];
                r_bp[k+1] <= r_bp[k];
            end
        end
    end

    // gain compensation, split product
    assign n_ux  = r_x[CORDIC_STEPS][DW-1] ? '0 : r_x[CORDIC_STEPS];
    assign n_phi = (XH_W+cmp_pkg::GAIN_W)'(n_ux[DW-1:cmp_pkg::LO_W])
                 * (XH_W+cmp_pkg::GAIN_W)'(cmp_pkg::INV_GAIN);
    assign n_plo = cmp_pkg::LO_PROD_W'(n_ux[cmp_pkg::LO_W-1:0])
                 * cmp_pkg::LO_PROD_W'(cmp_pkg::INV_GAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en_m) begin
            r_mv <= r_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_phi <= n_phi;
            r_plo <= n_plo;
            r_mz  <= r_z[CORDIC_STEPS];
            r_mbp <= r_bp[CORDIC_STEPS];
        end
    end

    // round, saturate, select bypass
    assign n_sum = cmp_pkg::SUM_W'(r_phi)
                 + cmp_pkg::SUM_W'(r_plo[cmp_pkg::LO_PROD_W-1:cmp_pkg::LO_W])
                 + cmp_pkg::MAG_ROUND;
    assign n_res = n_sum[cmp_pkg::SUM_W-1:cmp_pkg::LO_W];
    assign n_pz  = r_mz + cmp_pkg::PHASE_ROUND;

    always_comb begin
        if (r_mbp.spec) begin
            n_mag   = r_mbp.mag;
            n_phase = r_mbp.phase;
        end else begin
            n_mag   = (n_res > cmp_pkg::RES_W'(cmp_pkg::MAG_MAX)) ? cmp_pkg::MAG_MAX
                                                               : n_res[cmp_pkg::MAG_W-1:0];
            n_phase = n_pz[cmp_pkg::ANGLE_W-1:cmp_pkg::ANGLE_W-cmp_pkg::PHASE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_odata <= {n_phase, n_mag};
            r_ouser <= r_mbp.zero;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

>>> rtl/cmp_checker.sv
// Port-level assertions for the converter, bound to the top level.
module cmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 32'h0)
        else $error("zero sample gave nonzero magnitude or phase");

    a_nonzero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[15:0] != 16'h0)
        else $error("nonzero sample gave zero magnitude");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled without output backpressure");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind complex_magnitude_phase cmp_checker u_cmp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
